### design/lgps_pkg.sv
// ----------------------------------------------------------------------------
// lgps_pkg
// Types and codes shared by the LED group pattern sequencer modules.
// ----------------------------------------------------------------------------
package lgps_pkg;

  // Width of the LED on/off mask
  localparam int MASK_W = 16;

  // Mode codes
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_BLINK   = 3'd1;
  localparam logic [2:0] MODE_CHASE   = 3'd2;
  localparam logic [2:0] MODE_TWINKLE = 3'd3;
  localparam logic [2:0] MODE_ALL     = 3'd4;

  // Command codes
  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_SET_MODE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_LED_COUNT      = 2'd0;
  localparam logic [1:0] REG_BLINK_PERIOD   = 2'd1;
  localparam logic [1:0] REG_CHASE_PERIOD   = 2'd2;
  localparam logic [1:0] REG_TWINKLE_PERIOD = 2'd3;

  // Pattern loaded on chase entry (LEDs 0 and 2)
  localparam logic [MASK_W-1:0] CHASE_SEED = 16'h0005;

  typedef struct packed {
    logic       command;
    logic [2:0] mode_code;
    logic [3:0] random_pick;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] led_mask;
    logic              mode_accepted;
    logic [2:0]        active_mode;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        current_mode;
    logic [MASK_W-1:0] led_on_mask;
    logic              flash_phase;
    logic [MASK_W-1:0] chase_pattern;
    logic [1:0]        twinkle_phase;
    logic [3:0]        lit_index;
    logic [3:0]        pending_index;
    logic [15:0]       tick_count;
  } seq_state_t;

  typedef struct packed {
    logic [4:0]  led_num;
    logic [15:0] blink_period;
    logic [15:0] chase_period;
    logic [15:0] twinkle_period;
  } seq_cfg_t;

endpackage

### design/lgps_step.sv
// ----------------------------------------------------------------------------
// lgps_step
// Next-state and result logic for one transfer: mode entry, tick counting
// and the blink, chase and twinkle steps.
// ----------------------------------------------------------------------------
module lgps_step (
  input  lgps_pkg::seq_state_t state,
  input  lgps_pkg::seq_cfg_t   cfg,
  input  lgps_pkg::in_item_t   item,
  output lgps_pkg::seq_state_t state_next,
  output lgps_pkg::out_item_t  result
);
  import lgps_pkg::*;

  logic [MASK_W-1:0] in_use;
  logic [15:0]       period;
  logic [16:0]       tick_sum;
  logic              accepted;

  // Mask of the LEDs in use; led_num is already clamped to 2..16
  assign in_use = {MASK_W{1'b1}} >> (5'(MASK_W) - cfg.led_num);

  // Period of the running mode, zero read as one
  always_comb begin
    case (state.current_mode)
      MODE_BLINK: period = cfg.blink_period;
      MODE_CHASE: period = cfg.chase_period;
      default:    period = cfg.twinkle_period;
    endcase
    if (period == 16'd0) begin
      period = 16'd1;
    end
  end

  assign tick_sum = {1'b0, state.tick_count} + 17'd1;

  // State update
  always_comb begin
    logic [MASK_W-1:0] p;
    logic [4:0]        r;
    logic [1:0]        ph;
    state_next = state;
    accepted   = 1'b1;
    p  = '0;
    r  = '0;
    ph = '0;
    if (item.command == CMD_SET_MODE) begin
      if (item.mode_code > MODE_ALL) begin
        accepted = 1'b0;
      end else begin
        state_next.current_mode = item.mode_code;
        state_next.tick_count   = '0;
        case (item.mode_code)
          MODE_NONE: state_next.led_on_mask = state.led_on_mask & ~in_use;
          MODE_ALL:  state_next.led_on_mask = state.led_on_mask | in_use;
          MODE_BLINK: state_next.flash_phase = 1'b0;
          MODE_CHASE: state_next.chase_pattern = CHASE_SEED & in_use;
          default: begin
            // twinkle: LED 0 lit, pending pick clamped to count-1
            r = {1'b0, item.random_pick};
            if (r > cfg.led_num - 5'd1) begin
              r = cfg.led_num - 5'd1;
            end
            state_next.twinkle_phase = '0;
            state_next.lit_index     = '0;
            state_next.pending_index = r[3:0];
            state_next.led_on_mask   = state.led_on_mask | 16'd1;
          end
        endcase
      end
    end else if (state.current_mode == MODE_BLINK ||
                 state.current_mode == MODE_CHASE ||
                 state.current_mode == MODE_TWINKLE) begin
      if (tick_sum >= {1'b0, period}) begin
        state_next.tick_count = '0;
        case (state.current_mode)
          MODE_BLINK: begin
            state_next.flash_phase = ~state.flash_phase;
            if (state_next.flash_phase) begin
              state_next.led_on_mask = state.led_on_mask | in_use;
            end else begin
              state_next.led_on_mask = state.led_on_mask & ~in_use;
            end
          end
          MODE_CHASE: begin
            // rotate left within the LED count
            p = state.chase_pattern & in_use;
            p = ((p << 1) | MASK_W'(p[4'(cfg.led_num - 5'd1)])) & in_use;
            state_next.chase_pattern = p;
            state_next.led_on_mask   = (state.led_on_mask & ~in_use) | p;
          end
          default: begin
            // twinkle phase advances mod 3
            case (state.twinkle_phase)
              2'd2:    ph = 2'd0;
              2'd3:    ph = 2'd1;
              default: ph = state.twinkle_phase + 2'd1;
            endcase
            state_next.twinkle_phase = ph;
            if (ph == 2'd0) begin
              // new LED: clamp to count-2, then skip the lit one
              r = {1'b0, item.random_pick};
              if (r > cfg.led_num - 5'd2) begin
                r = cfg.led_num - 5'd2;
              end
              if (r >= {1'b0, state.lit_index}) begin
                r = r + 5'd1;
              end
              state_next.pending_index = r[3:0];
              state_next.led_on_mask   = state.led_on_mask |
                                         (MASK_W'(1) << r[3:0]);
            end else if (ph == 2'd1) begin
              state_next.led_on_mask = state.led_on_mask &
                                       ~(MASK_W'(1) << state.lit_index);
              state_next.lit_index   = state.pending_index;
            end
          end
        endcase
      end else begin
        state_next.tick_count = tick_sum[15:0];
      end
    end
  end

  // Result from the updated state
  assign result.led_mask      = state_next.led_on_mask & in_use;
  assign result.mode_accepted = accepted;
  assign result.active_mode   = state_next.current_mode;

endmodule

### design/led_group_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// led_group_pattern_sequencer_core
// On/off mask sequencer for a group of LEDs (none, all, blink, chase,
// twinkle), stepped by millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry ticks and mode commands. Every accepted
//   transfer yields exactly one result on out_valid/out_stall/out_data.
//   cfg_we/cfg_index/cfg_data write the LED count and the three periods;
//   write them only while the block is idle.
// Result: registered; it appears in the cycle after the input transfer.
// Throughput: one item per cycle when the output is not stalled. The whole
//   update is a single pass of lgps_step logic from state to output register.
// Stall: while out_valid is high and out_stall is asserted the output
//   register holds its result and in_stall is raised, so no input is
//   taken until the result is transferred; the output register is
//   refilled in the same cycle it drains.
// Reset (rst, synchronous): all LEDs off, mode none, counters clear, no
//   result pending; registers return to count 4 and periods 500/250/100.
// ----------------------------------------------------------------------------
module led_group_pattern_sequencer_core #(
  parameter int MAX_LEDS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lgps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lgps_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import lgps_pkg::*;

  localparam int LED_LIMIT = (MAX_LEDS < MASK_W) ? MAX_LEDS : MASK_W;

  logic [4:0]  led_count;
  logic [15:0] blink_period;
  logic [15:0] chase_period;
  logic [15:0] twinkle_period;

  seq_state_t state;
  seq_state_t state_next;
  seq_cfg_t   cfg;
  out_item_t  result;
  logic       in_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count      <= 5'd4;
      blink_period   <= 16'd500;
      chase_period   <= 16'd250;
      twinkle_period <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LED_COUNT:      led_count      <= cfg_data[4:0];
        REG_BLINK_PERIOD:   blink_period   <= cfg_data;
        REG_CHASE_PERIOD:   chase_period   <= cfg_data;
        REG_TWINKLE_PERIOD: twinkle_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective LED count, clamped to 2..LED_LIMIT
  always_comb begin
    cfg.led_num = led_count;
    if (cfg.led_num < 5'd2) begin
      cfg.led_num = 5'd2;
    end
    if (cfg.led_num > 5'(LED_LIMIT)) begin
      cfg.led_num = 5'(LED_LIMIT);
    end
    cfg.blink_period   = blink_period;
    cfg.chase_period   = chase_period;
    cfg.twinkle_period = twinkle_period;
  end

  lgps_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (in_data),
    .state_next (state_next),
    .result     (result)
  );

  // Input is held off only while a result waits on a stalled receiver
  assign in_stall = out_valid & out_stall;
  assign in_take  = in_valid & ~in_stall;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data <= result;
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED group pattern sequencer. A directed table
// covers mode entry, the invalid mode codes, the all-on and all-off masks and
// the LED count clamps. Random phases follow, each with fresh periods and
// count, driving mostly ticks mixed with mode changes. Every result is
// compared with its hand-written value or the local mode and mask model.
// ----------------------------------------------------------------------------
module tb;
  import lgps_pkg::*;

  localparam int LED_LIMIT   = 16;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 123;
  localparam int HOLD_AT     = 450;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  led_group_pattern_sequencer_core #(.MAX_LEDS(LED_LIMIT)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model copy of the registers
  logic [4:0]  leds_cfg     = 5'd4;
  logic [15:0] blink_cfg    = 16'd500;
  logic [15:0] chase_cfg    = 16'd250;
  logic [15:0] twinkle_cfg  = 16'd100;

  // Model copy of the sequencer state
  logic [2:0]  seq_mode     = MODE_NONE;
  logic [15:0] led_bits     = '0;
  logic        blink_on     = 1'b0;
  logic [15:0] chase_bits   = '0;
  int unsigned twinkle_step = 0;
  logic [3:0]  lit_led      = '0;
  logic [3:0]  next_led     = '0;
  int unsigned tick_run     = 0;

  out_item_t   led_results_due[$];
  int          error_count = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;

  // Directed plan: either a register write or an item, with an optional
  // hand-written result
  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_sel;
    logic [15:0] reg_val;
    in_item_t    item;
    bit          known;
    out_item_t   want;
  } plan_row_t;

  plan_row_t plan_rows[$];

  // Applies one item to the model state and returns the LED result
  function automatic out_item_t led_update(input in_item_t it);
    int unsigned n;
    int unsigned period;
    int unsigned r;
    int unsigned p;
    logic [15:0] used;
    out_item_t   res;
    n = leds_cfg;
    if (n < 2) n = 2;
    if (n > LED_LIMIT) n = LED_LIMIT;
    if (n > 16) n = 16;
    used = 16'((32'd1 << n) - 1);
    res.mode_accepted = 1'b1;
    if (it.command == CMD_SET_MODE) begin
      if (it.mode_code > MODE_ALL) begin
        res.mode_accepted = 1'b0;
      end else begin
        seq_mode = it.mode_code;
        tick_run = 0;
        case (it.mode_code)
          MODE_NONE:  led_bits = led_bits & ~used;
          MODE_ALL:   led_bits = led_bits | used;
          MODE_BLINK: blink_on = 1'b0;
          MODE_CHASE: chase_bits = CHASE_SEED & used;
          default: begin
            // twinkle entry: LED 0 lit, first pick clamped to count-1
            r = it.random_pick;
            if (r > n - 1) r = n - 1;
            twinkle_step = 0;
            lit_led      = '0;
            next_led     = r[3:0];
            led_bits[0]  = 1'b1;
          end
        endcase
      end
    end else if (seq_mode == MODE_BLINK || seq_mode == MODE_CHASE ||
                 seq_mode == MODE_TWINKLE) begin
      period = (seq_mode == MODE_BLINK) ? blink_cfg :
               (seq_mode == MODE_CHASE) ? chase_cfg : twinkle_cfg;
      if (period == 0) period = 1;
      tick_run++;
      if (tick_run >= period) begin
        tick_run = 0;
        case (seq_mode)
          MODE_BLINK: begin
            blink_on = ~blink_on;
            led_bits = blink_on ? (led_bits | used) : (led_bits & ~used);
          end
          MODE_CHASE: begin
            // rotate left within the LEDs in use
            p = chase_bits & used;
            p = ((p << 1) | ((p >> (n - 1)) & 1)) & used;
            chase_bits = p[15:0];
            led_bits   = (led_bits & ~used) | p[15:0];
          end
          default: begin
            twinkle_step = (twinkle_step + 1) % 3;
            if (twinkle_step == 0) begin
              // new LED: clamp, then skip over the one already lit
              r = it.random_pick;
              if (r > n - 2) r = n - 2;
              if (r >= lit_led) r++;
              next_led = r[3:0];
              led_bits[next_led] = 1'b1;
            end else if (twinkle_step == 1) begin
              led_bits[lit_led] = 1'b0;
              lit_led = next_led;
            end
          end
        endcase
      end
      tick_run = tick_run & 32'hFFFF;
    end
    res.led_mask    = led_bits & used;
    res.active_mode = seq_mode;
    return res;
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.random_pick = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 22) begin
      it.command = CMD_SET_MODE;
      if ($urandom_range(0, 9) == 0) it.mode_code = 3'($urandom_range(5, 7));
      else it.mode_code = 3'($urandom_range(0, 4));
    end else begin
      it.command   = CMD_TICK;
      it.mode_code = 3'($urandom_range(0, 7));
    end
    return it;
  endfunction

  task automatic plan_item(input logic cmd, input logic [2:0] code, input logic [3:0] pick);
    plan_row_t row;
    row.is_reg  = 1'b0;
    row.reg_sel = REG_LED_COUNT;
    row.reg_val = '0;
    row.item    = '{command: cmd, mode_code: code, random_pick: pick};
    row.known   = 1'b0;
    row.want    = '0;
    plan_rows.push_back(row);
  endtask

  task automatic plan_known(input logic cmd, input logic [2:0] code, input logic [3:0] pick,
                            input logic [15:0] mask, input logic acc, input logic [2:0] mode);
    plan_row_t row;
    row.is_reg  = 1'b0;
    row.reg_sel = REG_LED_COUNT;
    row.reg_val = '0;
    row.item    = '{command: cmd, mode_code: code, random_pick: pick};
    row.known   = 1'b1;
    row.want    = '{led_mask: mask, mode_accepted: acc, active_mode: mode};
    plan_rows.push_back(row);
  endtask

  task automatic plan_reg(input logic [1:0] sel, input logic [15:0] val);
    plan_row_t row;
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    row.item    = '0;
    row.known   = 1'b0;
    row.want    = '0;
    plan_rows.push_back(row);
  endtask

  // Offers one item and holds it until the transfer; the expected result is
  // queued at the transfer edge
  task automatic offer_item(input in_item_t it, input bit known, input out_item_t want);
    out_item_t res;
    cfg_we   <= 1'b0;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = led_update(it);
    led_results_due.push_back(known ? want : res);
    items_sent++;
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drains the block before a register write
  task automatic settle();
    in_valid <= 1'b0;
    while (led_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    case (sel)
      REG_LED_COUNT:    leds_cfg    = val[4:0];
      REG_BLINK_PERIOD: blink_cfg   = val;
      REG_CHASE_PERIOD: chase_cfg   = val;
      default:          twinkle_cfg = val;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Register settings per random phase; the first few are the extremes
  task automatic setup_phase(input int ph);
    logic [15:0] cnt, bp, cp, tp;
    case (ph)
      0: begin cnt = 16'd2;     bp = 16'd1;     cp = 16'd1;     tp = 16'd1;     end
      1: begin cnt = 16'd16;    bp = 16'd0;     cp = 16'd0;     tp = 16'd0;     end
      2: begin cnt = 16'hFFF1;  bp = 16'hFFFF;  cp = 16'd2;     tp = 16'd3;     end
      3: begin cnt = 16'd1;     bp = 16'd2;     cp = 16'hFFFF;  tp = 16'd1;     end
      default: begin
        cnt = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 31))
                                          : 16'($urandom_range(2, 16));
        bp = 16'($urandom_range(0, 5));
        cp = 16'($urandom_range(0, 5));
        tp = 16'($urandom_range(0, 5));
        if ($urandom_range(0, 9) == 0) bp = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) == 0) cp = 16'($urandom_range(0, 65535));
      end
    endcase
    settle();
    write_reg(REG_LED_COUNT, cnt);
    write_reg(REG_BLINK_PERIOD, bp);
    write_reg(REG_CHASE_PERIOD, cp);
    write_reg(REG_TWINKLE_PERIOD, tp);
  endtask

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (led_results_due.size() == 0) begin
        $error("result with no transfer pending: %h", out_data);
        error_count++;
      end else begin
        want = led_results_due.pop_front();
        if (out_data.led_mask !== want.led_mask) begin
          $error("led_mask: expected %h, got %h", want.led_mask, out_data.led_mask);
          error_count++;
        end
        if (out_data.mode_accepted !== want.mode_accepted) begin
          $error("mode_accepted: expected %b, got %b", want.mode_accepted,
                 out_data.mode_accepted);
          error_count++;
        end
        if (out_data.active_mode !== want.active_mode) begin
          $error("active_mode: expected %0d, got %0d", want.active_mode,
                 out_data.active_mode);
          error_count++;
        end
      end
    end
  end

  // Receiver stalls, with one long hold-off to back up the input
  initial begin
    bit held;
    int run;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : 1 + idle_len();
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        out_stall <= 1'b1;
        repeat (1 + idle_len()) @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus
  initial begin
    bit no_gaps;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_LED_COUNT;
    cfg_data  <= '0;

    // Reset defaults: count 4, mode none
    plan_known(CMD_TICK, 3'd0, 4'd0, 16'h0000, 1'b1, MODE_NONE);
    plan_known(CMD_SET_MODE, 3'd7, 4'd15, 16'h0000, 1'b0, MODE_NONE);
    plan_known(CMD_SET_MODE, 3'd5, 4'd0, 16'h0000, 1'b0, MODE_NONE);
    plan_known(CMD_SET_MODE, MODE_ALL, 4'd0, 16'h000F, 1'b1, MODE_ALL);
    plan_known(CMD_TICK, 3'd0, 4'd0, 16'h000F, 1'b1, MODE_ALL);
    plan_known(CMD_SET_MODE, MODE_NONE, 4'd0, 16'h0000, 1'b1, MODE_NONE);
    // Short periods so every tick steps; zero period on twinkle
    plan_reg(REG_BLINK_PERIOD, 16'd1);
    plan_reg(REG_CHASE_PERIOD, 16'd1);
    plan_reg(REG_TWINKLE_PERIOD, 16'd0);
    plan_item(CMD_SET_MODE, MODE_BLINK, 4'd0);
    plan_item(CMD_TICK, 3'd0, 4'd0);
    plan_item(CMD_TICK, 3'd0, 4'd0);
    plan_item(CMD_SET_MODE, MODE_CHASE, 4'd0);
    plan_item(CMD_TICK, 3'd0, 4'd0);
    plan_item(CMD_TICK, 3'd0, 4'd0);
    plan_item(CMD_TICK, 3'd0, 4'd0);
    plan_item(CMD_SET_MODE, MODE_TWINKLE, 4'd15);
    plan_item(CMD_TICK, 3'd0, 4'd15);
    plan_item(CMD_TICK, 3'd0, 4'd0);
    plan_item(CMD_TICK, 3'd0, 4'd3);
    plan_item(CMD_TICK, 3'd0, 4'd15);
    plan_item(CMD_TICK, 3'd0, 4'd0);
    plan_item(CMD_TICK, 3'd0, 4'd7);
    // LED count below and above the legal range
    plan_reg(REG_LED_COUNT, 16'd0);
    plan_known(CMD_SET_MODE, MODE_ALL, 4'd0, 16'h0003, 1'b1, MODE_ALL);
    plan_reg(REG_LED_COUNT, 16'd31);
    plan_known(CMD_SET_MODE, MODE_ALL, 4'd0, 16'hFFFF, 1'b1, MODE_ALL);
    plan_item(CMD_SET_MODE, MODE_CHASE, 4'd0);
    plan_item(CMD_TICK, 3'd0, 4'd0);
    plan_known(CMD_SET_MODE, MODE_NONE, 4'd0, 16'h0000, 1'b1, MODE_NONE);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_reg) begin
        settle();
        write_reg(plan_rows[i].reg_sel, plan_rows[i].reg_val);
      end else begin
        offer_item(plan_rows[i].item, plan_rows[i].known, plan_rows[i].want);
        pause_input(idle_len());
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      setup_phase(ph);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        offer_item(rand_item(), 1'b0, '0);
        if (!no_gaps) pause_input(idle_len());
      end
    end

    // Drain and let the pipe go quiet
    in_valid <= 1'b0;
    while (led_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
